/* rtl/dehp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the VR class lookup for the DICOM element header parser.
// No dependencies; every other file imports this package.
package dehp_pkg;

  // Stream layout
  localparam int unsigned PREAMBLE_BYTES = 128;
  localparam logic [31:0] PREFIX_WORD    = "DICM";

  // Tags and lengths
  localparam logic [15:0] TAG_ITEM_GROUP    = 16'hFFFE;
  localparam logic [15:0] TAG_ITEM          = 16'hE000;
  localparam logic [15:0] TAG_ITEM_DELIM    = 16'hE00D;
  localparam logic [15:0] TAG_SEQ_DELIM     = 16'hE0DD;
  localparam logic [15:0] TAG_PIXEL_GROUP   = 16'h7FE0;
  localparam logic [15:0] TAG_PIXEL_ELEMENT = 16'h0010;
  localparam logic [31:0] UNDEF_LEN         = 32'hFFFFFFFF;
  localparam logic [31:0] FRAG_OFFSET       = 32'd8;
  localparam logic [3:0]  HDR_SHORT         = 4'd8;
  localparam logic [3:0]  HDR_LONG          = 4'd12;
  localparam logic [3:0]  PREFIX_LEN        = 4'd4;

  // Event queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_PREAMBLE,
    PH_PREFIX,
    PH_HEADER,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RES_ELEMENT   = 2'd0,
    RES_NOT_DICOM = 2'd1,
    RES_END       = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    VRC_IMPLICIT,
    VRC_SHORT,
    VRC_LONG
  } vr_class_t;

  // One parsed event handed from the front to the back
  typedef struct packed {
    result_kind_t kind;
    logic [15:0]  group;
    logic [15:0]  element;
    logic [15:0]  vr;
    logic [31:0]  len;
    vr_class_t    cls;
    logic [31:0]  start;
  } dehp_event_t;

  // Up to two events pushed per byte, in order
  typedef struct packed {
    logic        v0;
    logic        v1;
    dehp_event_t ev0;
    dehp_event_t ev1;
  } dehp_push_t;

  // Header form selected by the VR characters
  function automatic vr_class_t vr_class(logic [15:0] vr);
    vr_class_t c;
    case (vr)
      "AE", "AS", "AT", "CS", "DA", "DS", "DT", "FL", "FD", "IS", "LO",
      "LT", "PN", "SH", "SL", "SS", "ST", "TM", "UI", "UL", "US": c = VRC_SHORT;
      "OB", "OF", "OW", "SQ", "UN", "UT": c = VRC_LONG;
      default: c = VRC_IMPLICIT;
    endcase
    return c;
  endfunction

endpackage

/* rtl/dehp_front.sv */
`timescale 1ns / 1ps
// Front end: byte acceptance, preamble/prefix/header/skip sequencing, event generation.
// Depends on dehp_pkg; pushes events into dehp_queue.
module dehp_front import dehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        q_room2,
  output dehp_push_t  push
);

  phase_t      phase_r, phase_nxt, cur_phase, mid_phase;
  logic [31:0] byte_pos_r, byte_pos_nxt;
  logic [7:0]  hdr_r [0:11];
  logic [7:0]  hdr_nxt [0:11];
  logic [3:0]  hcnt_r, hcnt_nxt, hcnt_inc, wr_idx;
  logic [31:0] hstart_r, hstart_nxt;
  logic [31:0] skip_r, skip_nxt, skip_dec;
  logic        accept, hdr_wr;
  logic [15:0] grp, elm, vr;
  vr_class_t   cls;
  logic        prefix_full, prefix_ok, hdr_done, skip_end;
  logic [31:0] len, skip_len;
  dehp_event_t ev_hdr, ev_last;

  assign in_stall = !q_room2;
  assign accept   = in_valid && !in_stall;

  // Decode the current byte against the stored header bytes
  always_comb begin
    cur_phase = phase_r;
    if (phase_r == PH_PREAMBLE && byte_pos_r >= 32'(PREAMBLE_BYTES)) begin
      cur_phase = PH_PREFIX;
    end
    hcnt_inc = hcnt_r + 4'd1;
    wr_idx   = (cur_phase == PH_PREFIX) ? {2'b00, hcnt_r[1:0]} : hcnt_r;
    hdr_wr   = (cur_phase == PH_PREFIX) || (cur_phase == PH_HEADER);
    for (int i = 0; i < 12; i++) begin
      hdr_nxt[i] = (hdr_wr && wr_idx == 4'(i)) ? in_data_byte : hdr_r[i];
    end
    grp = {hdr_nxt[1], hdr_nxt[0]};
    elm = {hdr_nxt[3], hdr_nxt[2]};
    vr  = {hdr_nxt[4], hdr_nxt[5]};
    cls = vr_class(vr);
    // Item and delimiter tags are always implicit
    if (grp == TAG_ITEM_GROUP &&
        (elm == TAG_ITEM || elm == TAG_ITEM_DELIM || elm == TAG_SEQ_DELIM)) begin
      cls = VRC_IMPLICIT;
    end
    prefix_full = (cur_phase == PH_PREFIX) && (hcnt_inc == PREFIX_LEN);
    prefix_ok   = {hdr_nxt[0], hdr_nxt[1], hdr_nxt[2], hdr_nxt[3]} == PREFIX_WORD;
    hdr_done    = (cur_phase == PH_HEADER) &&
                  ((hcnt_inc == HDR_SHORT && cls != VRC_LONG) || hcnt_inc == HDR_LONG);
    case (cls)
      VRC_SHORT: len = {16'h0000, hdr_nxt[7], hdr_nxt[6]};
      VRC_LONG:  len = {hdr_nxt[11], hdr_nxt[10], hdr_nxt[9], hdr_nxt[8]};
      default:   len = {hdr_nxt[7], hdr_nxt[6], hdr_nxt[5], hdr_nxt[4]};
    endcase
    skip_len = (len == UNDEF_LEN) ? 32'd0 : len;
    skip_dec = skip_r - 32'd1;
    skip_end = (cur_phase == PH_SKIP) && (skip_dec == 32'd0);
  end

  // Next phase
  always_comb begin
    mid_phase = cur_phase;
    case (cur_phase)
      PH_PREFIX: if (prefix_full) begin
        mid_phase = prefix_ok ? PH_HEADER : PH_DONE;
      end
      PH_HEADER: if (hdr_done) begin
        mid_phase = (skip_len != 32'd0) ? PH_SKIP : PH_HEADER;
      end
      PH_SKIP: if (skip_end) begin
        mid_phase = PH_HEADER;
      end
      default: mid_phase = cur_phase;
    endcase
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = in_last_byte ? PH_PREAMBLE : mid_phase;
    end
  end

  // Counters, header position, skip count and events
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    hcnt_nxt     = hcnt_r;
    hstart_nxt   = hstart_r;
    skip_nxt     = skip_r;
    if (accept) begin
      byte_pos_nxt = byte_pos_r + 32'd1;
      case (cur_phase)
        PH_PREFIX: hcnt_nxt = prefix_full ? 4'd0 : hcnt_inc;
        PH_HEADER: begin
          if (hcnt_r == 4'd0) begin
            hstart_nxt = byte_pos_r;
          end
          hcnt_nxt = hdr_done ? 4'd0 : hcnt_inc;
          if (hdr_done) begin
            skip_nxt = skip_len;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_end) begin
            hcnt_nxt = 4'd0;
          end
        end
        default: hcnt_nxt = hcnt_r;
      endcase
      // Final byte: start over for the next file
      if (in_last_byte) begin
        byte_pos_nxt = 32'd0;
        hcnt_nxt     = 4'd0;
        hstart_nxt   = 32'd0;
        skip_nxt     = 32'd0;
      end
    end

    ev_hdr = '0;
    if (hdr_done) begin
      ev_hdr.kind    = RES_ELEMENT;
      ev_hdr.group   = grp;
      ev_hdr.element = elm;
      ev_hdr.vr      = vr;
      ev_hdr.len     = len;
      ev_hdr.cls     = cls;
      ev_hdr.start   = (hcnt_r == 4'd0) ? byte_pos_r : hstart_r;
    end else begin
      ev_hdr.kind = RES_NOT_DICOM;
    end

    ev_last = '0;
    ev_last.kind = (mid_phase == PH_HEADER || mid_phase == PH_SKIP) ? RES_END : RES_NOT_DICOM;

    push.v0  = accept && (hdr_done || (prefix_full && !prefix_ok));
    push.v1  = accept && in_last_byte && (mid_phase != PH_DONE);
    push.ev0 = ev_hdr;
    push.ev1 = ev_last;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PREAMBLE;
      byte_pos_r <= 32'd0;
      hcnt_r     <= 4'd0;
      hstart_r   <= 32'd0;
      skip_r     <= 32'd0;
    end else begin
      phase_r    <= phase_nxt;
      byte_pos_r <= byte_pos_nxt;
      hcnt_r     <= hcnt_nxt;
      hstart_r   <= hstart_nxt;
      skip_r     <= skip_nxt;
    end
  end

  // Header byte store
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 12; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

endmodule

/* rtl/dehp_queue.sv */
`timescale 1ns / 1ps
// Event queue between the front and back: two pushes and one pop per cycle.
// Depends on dehp_pkg.
module dehp_queue import dehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dehp_push_t  push,
  input  logic        pop,
  output dehp_event_t head,
  output logic        not_empty,
  output logic        room2
);

  dehp_event_t         slot_r [0:QUEUE_DEPTH-1];
  logic [QUEUE_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_second;
  logic [QUEUE_CW-1:0] cnt_r, cnt_nxt;

  assign head      = slot_r[rp_r];
  assign not_empty = cnt_r != '0;
  assign room2     = cnt_r <= QUEUE_CW'(QUEUE_DEPTH - 2);
  assign wp_second = wp_r + QUEUE_AW'(push.v0);

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = wp_r + QUEUE_AW'(push.v0) + QUEUE_AW'(push.v1);
    rp_nxt  = rp_r + QUEUE_AW'(pop);
    cnt_nxt = cnt_r + QUEUE_CW'(push.v0) + QUEUE_CW'(push.v1) - QUEUE_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store events in push order
  always_ff @(posedge clk) begin
    if (push.v0) begin
      slot_r[wp_r] <= push.ev0;
    end
    if (push.v1) begin
      slot_r[wp_second] <= push.ev1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("event queue count past depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v0 || push.v1) |-> room2)
    else $error("event pushed without room");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("event popped from empty queue");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v0 && push.v1) |-> (push.ev1.kind != RES_ELEMENT))
    else $error("element event pushed behind another event");

endmodule

/* rtl/dehp_back.sv */
`timescale 1ns / 1ps
// Back end: encapsulation tracking, fragment positions and the output register.
// Depends on dehp_pkg; pops events from dehp_queue.
module dehp_back import dehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dehp_event_t head,
  input  logic        not_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_group_number,
  output logic [15:0] out_element_number,
  output logic [15:0] out_vr_code,
  output logic [31:0] out_value_length,
  output logic [3:0]  out_header_bytes,
  output logic        out_explicit_vr,
  output logic        out_long_length,
  output logic        out_is_offset_table,
  output logic        out_is_jpeg_fragment,
  output logic [31:0] out_fragment_position,
  output logic [31:0] out_first_jpeg_position
);

  logic        enc_r, enc_nxt, otn_r, otn_nxt;
  logic [31:0] first_r, first_nxt;
  logic        ot, jf, is_elem;
  logic [31:0] fp, first_out;

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [15:0] group_r, element_r, vr_r;
  logic [31:0] len_r, fp_r, first_pos_r;
  logic [3:0]  hb_r;
  logic        ex_r, ll_r, ot_r, jf_r;

  assign pop     = not_empty && (!valid_r || !out_stall);
  assign is_elem = head.kind == RES_ELEMENT;

  // Classify the head event against the encapsulation state
  always_comb begin
    enc_nxt   = enc_r;
    otn_nxt   = otn_r;
    first_nxt = first_r;
    ot        = 1'b0;
    jf        = 1'b0;
    fp        = 32'd0;
    first_out = 32'd0;
    case (head.kind)
      RES_ELEMENT: begin
        if (!enc_r) begin
          if (head.group == TAG_PIXEL_GROUP && head.element == TAG_PIXEL_ELEMENT &&
              head.len == UNDEF_LEN) begin
            enc_nxt = 1'b1;
            otn_nxt = 1'b1;
          end
        end else if (head.group == TAG_ITEM_GROUP && head.element == TAG_ITEM) begin
          if (otn_r) begin
            otn_nxt = 1'b0;
            ot      = 1'b1;
          end else begin
            jf = 1'b1;
          end
        end else if (head.group == TAG_ITEM_GROUP && head.element == TAG_SEQ_DELIM) begin
          enc_nxt = 1'b0;
        end
        if (jf) begin
          fp = head.start + FRAG_OFFSET;
          if (fp != 32'd0 && first_r == 32'd0) begin
            first_nxt = fp;
          end
        end
        first_out = first_nxt;
      end
      RES_END: begin
        first_out = first_r;
        enc_nxt   = 1'b0;
        otn_nxt   = 1'b0;
        first_nxt = 32'd0;
      end
      default: begin
        enc_nxt   = 1'b0;
        otn_nxt   = 1'b0;
        first_nxt = 32'd0;
      end
    endcase
  end

  // Control state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r   <= 1'b0;
      otn_r   <= 1'b0;
      first_r <= 32'd0;
      valid_r <= 1'b0;
    end else begin
      if (pop) begin
        enc_r   <= enc_nxt;
        otn_r   <= otn_nxt;
        first_r <= first_nxt;
      end
      if (pop) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload; hold while stalled
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r      <= head.kind;
      group_r     <= is_elem ? head.group : 16'd0;
      element_r   <= is_elem ? head.element : 16'd0;
      vr_r        <= is_elem ? head.vr : 16'd0;
      len_r       <= is_elem ? head.len : 32'd0;
      hb_r        <= !is_elem ? 4'd0 : (head.cls == VRC_LONG ? HDR_LONG : HDR_SHORT);
      ex_r        <= is_elem && head.cls != VRC_IMPLICIT;
      ll_r        <= is_elem && head.cls != VRC_SHORT;
      ot_r        <= ot;
      jf_r        <= jf;
      fp_r        <= fp;
      first_pos_r <= first_out;
    end
  end

  assign out_valid               = valid_r;
  assign out_result_kind         = kind_r;
  assign out_group_number        = group_r;
  assign out_element_number      = element_r;
  assign out_vr_code             = vr_r;
  assign out_value_length        = len_r;
  assign out_header_bytes        = hb_r;
  assign out_explicit_vr         = ex_r;
  assign out_long_length         = ll_r;
  assign out_is_offset_table     = ot_r;
  assign out_is_jpeg_fragment    = jf_r;
  assign out_fragment_position   = fp_r;
  assign out_first_jpeg_position = first_pos_r;

endmodule

/* rtl/dicom_element_header_parser.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   data_byte[7:0], last_byte
// out_      output     out_valid/out_stall kind, tag, VR, length, encapsulation info
//
// One byte is taken per cycle while in_stall is low; the front sequencer decodes each byte
// as it is taken. A result passes through the event queue and then the output register; a
// header that ends on the final byte yields two results, its element and then an end result.
// A four-entry event queue separates the sequencer from the output stage; in_stall is
// high while it holds more than two events, so a stalled output stops input after that.
// Reset is synchronous and clears sequencer, queue and encapsulation state at once.
// Top level of the DICOM element header parser; depends on dehp_pkg, dehp_front,
// dehp_queue and dehp_back.
module dicom_element_header_parser import dehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_group_number,
  output logic [15:0] out_element_number,
  output logic [15:0] out_vr_code,
  output logic [31:0] out_value_length,
  output logic [3:0]  out_header_bytes,
  output logic        out_explicit_vr,
  output logic        out_long_length,
  output logic        out_is_offset_table,
  output logic        out_is_jpeg_fragment,
  output logic [31:0] out_fragment_position,
  output logic [31:0] out_first_jpeg_position
);

  dehp_push_t  push;
  dehp_event_t head;
  logic        pop, not_empty, room2;

  // Byte sequencer
  dehp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_room2      (room2),
    .push         (push)
  );

  // Event queue
  dehp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  // Encapsulation tracking and output register
  dehp_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .head                    (head),
    .not_empty               (not_empty),
    .pop                     (pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_result_kind         (out_result_kind),
    .out_group_number        (out_group_number),
    .out_element_number      (out_element_number),
    .out_vr_code             (out_vr_code),
    .out_value_length        (out_value_length),
    .out_header_bytes        (out_header_bytes),
    .out_explicit_vr         (out_explicit_vr),
    .out_long_length         (out_long_length),
    .out_is_offset_table     (out_is_offset_table),
    .out_is_jpeg_fragment    (out_is_jpeg_fragment),
    .out_fragment_position   (out_fragment_position),
    .out_first_jpeg_position (out_first_jpeg_position)
  );

endmodule

/* test/element_header_check.sv */
`timescale 1ns / 1ps
// Checker for the DICOM element header parser: watches both channels, predicts each result.
// Compares results field by field. Depends on dehp_pkg for tags, phases and kinds.
module element_header_check import dehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_result_kind,
  input  logic [15:0] out_group_number,
  input  logic [15:0] out_element_number,
  input  logic [15:0] out_vr_code,
  input  logic [31:0] out_value_length,
  input  logic [3:0]  out_header_bytes,
  input  logic        out_explicit_vr,
  input  logic        out_long_length,
  input  logic        out_is_offset_table,
  input  logic        out_is_jpeg_fragment,
  input  logic [31:0] out_fragment_position,
  input  logic [31:0] out_first_jpeg_position,
  output int unsigned mismatches,
  output int unsigned pending_results,
  output int unsigned results_checked
);

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] grp;
    logic [15:0] elem;
    logic [15:0] vr;
    logic [31:0] len;
    logic [3:0]  hdr_bytes;
    logic        explicit_vr;
    logic        long_len;
    logic        offset_table;
    logic        jpeg_frag;
    logic [31:0] frag_pos;
    logic [31:0] first_jpeg;
  } header_result_t;

  header_result_t expected_headers[$];
  header_result_t oldest;

  // Parser state mirrored from the input transactions
  logic [31:0] file_pos;
  phase_t      stage;
  logic [7:0]  hdr_buf [12];
  logic [3:0]  hdr_count;
  logic [31:0] hdr_start;
  logic [31:0] skip_left;
  logic        in_encap;
  logic        table_next;
  logic [31:0] first_frag_pos;

  // Header layout chosen by the two VR characters
  function automatic vr_class_t vr_layout(input logic [15:0] vr);
    case (vr)
      "AE", "AS", "AT", "CS", "DA", "DS", "DT", "FL", "FD", "IS", "LO",
      "LT", "PN", "SH", "SL", "SS", "ST", "TM", "UI", "UL", "US": return VRC_SHORT;
      "OB", "OF", "OW", "SQ", "UN", "UT": return VRC_LONG;
      default: return VRC_IMPLICIT;
    endcase
  endfunction

  function automatic header_result_t blank_result();
    header_result_t r;
    r.kind         = RES_ELEMENT;
    r.grp          = '0;
    r.elem         = '0;
    r.vr           = '0;
    r.len          = '0;
    r.hdr_bytes    = '0;
    r.explicit_vr  = 1'b0;
    r.long_len     = 1'b0;
    r.offset_table = 1'b0;
    r.jpeg_frag    = 1'b0;
    r.frag_pos     = '0;
    r.first_jpeg   = '0;
    return r;
  endfunction

  task automatic clear_parser();
    file_pos       = '0;
    stage          = PH_PREAMBLE;
    hdr_count      = '0;
    hdr_start      = '0;
    skip_left      = '0;
    in_encap       = 1'b0;
    table_next     = 1'b0;
    first_frag_pos = '0;
  endtask

  // Queue a not-DICOM or end-of-stream result
  task automatic push_flag(input result_kind_t k);
    header_result_t r;
    r = blank_result();
    r.kind = k;
    if (k == RES_END) r.first_jpeg = first_frag_pos;
    expected_headers.push_back(r);
  endtask

  // Header complete: queue its result, track encapsulation, set up the value skip
  task automatic close_header(input vr_class_t form);
    header_result_t r;
    logic [15:0]    g;
    logic [15:0]    e;
    r = blank_result();
    g = {hdr_buf[1], hdr_buf[0]};
    e = {hdr_buf[3], hdr_buf[2]};
    r.grp  = g;
    r.elem = e;
    r.vr   = {hdr_buf[4], hdr_buf[5]};
    case (form)
      VRC_SHORT: begin
        r.len         = {16'h0000, hdr_buf[7], hdr_buf[6]};
        r.hdr_bytes   = HDR_SHORT;
        r.explicit_vr = 1'b1;
        r.long_len    = 1'b0;
      end
      VRC_LONG: begin
        r.len         = {hdr_buf[11], hdr_buf[10], hdr_buf[9], hdr_buf[8]};
        r.hdr_bytes   = HDR_LONG;
        r.explicit_vr = 1'b1;
        r.long_len    = 1'b1;
      end
      default: begin
        r.len         = {hdr_buf[7], hdr_buf[6], hdr_buf[5], hdr_buf[4]};
        r.hdr_bytes   = HDR_SHORT;
        r.explicit_vr = 1'b0;
        r.long_len    = 1'b1;
      end
    endcase

    if (!in_encap) begin
      if (g == TAG_PIXEL_GROUP && e == TAG_PIXEL_ELEMENT && r.len == UNDEF_LEN) begin
        in_encap   = 1'b1;
        table_next = 1'b1;
      end
    end else if (g == TAG_ITEM_GROUP && e == TAG_ITEM) begin
      if (table_next) begin
        table_next     = 1'b0;
        r.offset_table = 1'b1;
      end else begin
        r.jpeg_frag = 1'b1;
      end
    end else if (g == TAG_ITEM_GROUP && e == TAG_SEQ_DELIM) begin
      in_encap = 1'b0;
    end

    if (r.jpeg_frag) begin
      r.frag_pos = hdr_start + FRAG_OFFSET;
      if (r.frag_pos != 0 && first_frag_pos == 0) first_frag_pos = r.frag_pos;
    end
    r.first_jpeg = first_frag_pos;
    expected_headers.push_back(r);

    hdr_count = '0;
    skip_left = (r.len == UNDEF_LEN) ? 32'h0 : r.len;
    stage     = (skip_left != 0) ? PH_SKIP : PH_HEADER;
  endtask

  // Advance the parser by one accepted byte
  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [31:0] pos;
    vr_class_t   form;
    logic [15:0] g;
    logic [15:0] e;
    pos      = file_pos;
    file_pos = pos + 32'd1;

    if (stage == PH_PREAMBLE && pos >= PREAMBLE_BYTES) begin
      stage     = PH_PREFIX;
      hdr_count = '0;
    end

    case (stage)
      PH_PREFIX: begin
        hdr_buf[hdr_count[1:0]] = b;
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= PREFIX_LEN) begin
          hdr_count = '0;
          if ({hdr_buf[0], hdr_buf[1], hdr_buf[2], hdr_buf[3]} == PREFIX_WORD) begin
            stage = PH_HEADER;
          end else begin
            push_flag(RES_NOT_DICOM);
            stage = PH_DONE;
          end
        end
      end
      PH_HEADER: begin
        if (hdr_count == 0) hdr_start = pos;
        if (hdr_count < HDR_LONG) hdr_buf[hdr_count] = b;
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= HDR_SHORT) begin
          form = vr_layout({hdr_buf[4], hdr_buf[5]});
          g    = {hdr_buf[1], hdr_buf[0]};
          e    = {hdr_buf[3], hdr_buf[2]};
          // item tags are always implicit
          if (g == TAG_ITEM_GROUP &&
              (e == TAG_ITEM || e == TAG_ITEM_DELIM || e == TAG_SEQ_DELIM))
            form = VRC_IMPLICIT;
          if (hdr_count >= ((form == VRC_LONG) ? HDR_LONG : HDR_SHORT)) close_header(form);
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) begin
          stage     = PH_HEADER;
          hdr_count = '0;
        end
      end
      default: ;
    endcase

    // final byte: report how the file ended, then start over
    if (last) begin
      if (stage == PH_PREAMBLE || stage == PH_PREFIX) push_flag(RES_NOT_DICOM);
      else if (stage == PH_HEADER || stage == PH_SKIP) push_flag(RES_END);
      clear_parser();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on input transactions, compare on result transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_headers.delete();
      mismatches      = 0;
      results_checked = 0;
    end else begin
      if (in_valid && !in_stall) predict_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_headers.size() == 0) begin
          $error("result_kind: expected no result, got 0x%0h", out_result_kind);
          mismatches++;
        end else begin
          oldest = expected_headers.pop_front();
          check_field("result_kind", 32'(oldest.kind), 32'(out_result_kind));
          check_field("group_number", 32'(oldest.grp), 32'(out_group_number));
          check_field("element_number", 32'(oldest.elem), 32'(out_element_number));
          check_field("vr_code", 32'(oldest.vr), 32'(out_vr_code));
          check_field("value_length", oldest.len, out_value_length);
          check_field("header_bytes", 32'(oldest.hdr_bytes), 32'(out_header_bytes));
          check_field("explicit_vr", 32'(oldest.explicit_vr), 32'(out_explicit_vr));
          check_field("long_length", 32'(oldest.long_len), 32'(out_long_length));
          check_field("is_offset_table", 32'(oldest.offset_table),
                      32'(out_is_offset_table));
          check_field("is_jpeg_fragment", 32'(oldest.jpeg_frag), 32'(out_is_jpeg_fragment));
          check_field("fragment_position", oldest.frag_pos, out_fragment_position);
          check_field("first_jpeg_position", oldest.first_jpeg, out_first_jpeg_position);
        end
      end
    end
    pending_results = expected_headers.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Top of the DICOM element header parser bench: builds byte files, drives them, gives the verdict.
// Depends on dehp_pkg, the parser RTL and element_header_check.
module testbench;
  import dehp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned BYTE_TARGET = 1050;
  localparam int unsigned WHOLE_VALUE = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [15:0] out_group_number;
  logic [15:0] out_element_number;
  logic [15:0] out_vr_code;
  logic [31:0] out_value_length;
  logic [3:0]  out_header_bytes;
  logic        out_explicit_vr;
  logic        out_long_length;
  logic        out_is_offset_table;
  logic        out_is_jpeg_fragment;
  logic [31:0] out_fragment_position;
  logic [31:0] out_first_jpeg_position;

  int unsigned mismatches;
  int unsigned pending_results;
  int unsigned results_checked;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned pick;
  int unsigned idx;
  logic        calm = 1'b0;
  logic [7:0]  file_q[$];

  dicom_element_header_parser dut (.*);
  element_header_check header_check (.*);

  always #10 clk = ~clk;

  // Stall results at random, except during the calm stretch
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 26);

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_vr(input vr_class_t form);
    logic [15:0] vr;
    if (form == VRC_LONG) begin
      case ($urandom_range(5))
        0: vr = "OB";
        1: vr = "OF";
        2: vr = "OW";
        3: vr = "SQ";
        4: vr = "UN";
        default: vr = "UT";
      endcase
    end else begin
      case ($urandom_range(20))
        0: vr = "AE";  1: vr = "AS";  2: vr = "AT";  3: vr = "CS";  4: vr = "DA";
        5: vr = "DS";  6: vr = "DT";  7: vr = "FL";  8: vr = "FD";  9: vr = "IS";
        10: vr = "LO"; 11: vr = "LT"; 12: vr = "PN"; 13: vr = "SH"; 14: vr = "SL";
        15: vr = "SS"; 16: vr = "ST"; 17: vr = "TM"; 18: vr = "UI"; 19: vr = "UL";
        default: vr = "US";
      endcase
    end
    return vr;
  endfunction

  task automatic add_u16le(input logic [15:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endtask

  task automatic add_u32le(input logic [31:0] v);
    add_u16le(v[15:0]);
    add_u16le(v[31:16]);
  endtask

  task automatic add_junk(input int unsigned n);
    repeat (n) file_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_preamble();
    add_junk(PREAMBLE_BYTES);
  endtask

  task automatic add_prefix();
    file_q.push_back(PREFIX_WORD[31:24]);
    file_q.push_back(PREFIX_WORD[23:16]);
    file_q.push_back(PREFIX_WORD[15:8]);
    file_q.push_back(PREFIX_WORD[7:0]);
  endtask

  // Append one element header in the given layout, then up to body_cap value bytes
  task automatic add_element(input logic [15:0] g, input logic [15:0] e, input logic [15:0] vr,
                             input vr_class_t form, input logic [31:0] len,
                             input int unsigned body_cap);
    int unsigned body;
    add_u16le(g);
    add_u16le(e);
    case (form)
      VRC_SHORT: begin
        file_q.push_back(vr[15:8]);
        file_q.push_back(vr[7:0]);
        add_u16le(len[15:0]);
      end
      VRC_LONG: begin
        file_q.push_back(vr[15:8]);
        file_q.push_back(vr[7:0]);
        add_u16le(16'($urandom_range(65535)));
        add_u32le(len);
      end
      default: add_u32le(len);
    endcase
    body = (len == UNDEF_LEN) ? 0 : ((len < body_cap) ? len : body_cap);
    add_junk(body);
  endtask

  // Pixel data of undefined length: offset table, fragments, sequence delimiter
  task automatic add_encapsulation(input int unsigned frags, input logic nested);
    int unsigned n;
    add_element(TAG_PIXEL_GROUP, TAG_PIXEL_ELEMENT, "OB", VRC_LONG, UNDEF_LEN, WHOLE_VALUE);
    add_element(TAG_ITEM_GROUP, TAG_ITEM, 16'h0, VRC_IMPLICIT, $urandom_range(1) * 4,
                WHOLE_VALUE);
    for (n = 0; n < frags; n++) begin
      add_element(TAG_ITEM_GROUP, TAG_ITEM, 16'h0, VRC_IMPLICIT, $urandom_range(1, 10),
                  WHOLE_VALUE);
      // nested pixel data must not reopen; item delimiter is passed through
      if (nested && n == 0) begin
        add_element(TAG_PIXEL_GROUP, TAG_PIXEL_ELEMENT, "OB", VRC_LONG, UNDEF_LEN, WHOLE_VALUE);
        add_element(TAG_ITEM_GROUP, TAG_ITEM_DELIM, 16'h0, VRC_IMPLICIT, 0, WHOLE_VALUE);
      end
    end
    add_element(TAG_ITEM_GROUP, TAG_SEQ_DELIM, 16'h0, VRC_IMPLICIT, 0, WHOLE_VALUE);
  endtask

  task automatic add_random_element();
    int unsigned kind_pick;
    logic [15:0] g;
    logic [15:0] item_el;
    kind_pick = $urandom_range(99);
    g = $urandom_range(1) ? 16'h0008 : 16'($urandom_range(65535));
    if (kind_pick < 30) begin
      add_element(g, 16'($urandom_range(65535)), pick_vr(VRC_SHORT), VRC_SHORT,
                  $urandom_range(8), WHOLE_VALUE);
    end else if (kind_pick < 45) begin
      add_element(g, 16'($urandom_range(65535)), pick_vr(VRC_LONG), VRC_LONG,
                  ($urandom_range(6) == 0) ? UNDEF_LEN : 32'($urandom_range(10)), WHOLE_VALUE);
    end else if (kind_pick < 58) begin
      add_element(g, 16'($urandom_range(65535)), 16'h0, VRC_IMPLICIT, $urandom_range(8),
                  WHOLE_VALUE);
    end else if (kind_pick < 68) begin
      case ($urandom_range(2))
        0: item_el = TAG_ITEM;
        1: item_el = TAG_ITEM_DELIM;
        default: item_el = TAG_SEQ_DELIM;
      endcase
      add_element(TAG_ITEM_GROUP, item_el, 16'h0, VRC_IMPLICIT, $urandom_range(4), WHOLE_VALUE);
    end else if (kind_pick < 84) begin
      add_encapsulation($urandom_range(1, 3), 1'($urandom_range(1)));
    end else if (kind_pick < 93) begin
      add_element(TAG_PIXEL_GROUP, TAG_PIXEL_ELEMENT, $urandom_range(1) ? "OW" : "OB",
                  VRC_LONG, $urandom_range(2, 8), WHOLE_VALUE);
    end else begin
      // implicit pixel data of undefined length also opens an encapsulation
      add_element(TAG_PIXEL_GROUP, TAG_PIXEL_ELEMENT, 16'h0, VRC_IMPLICIT, UNDEF_LEN,
                  WHOLE_VALUE);
    end
  endtask

  // Drive one input transaction; hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_file();
    int unsigned n;
    for (n = 0; n < file_q.size(); n++) begin
      send_byte(file_q[n], n == file_q.size() - 1);
      bytes_sent++;
    end
    file_q.delete();
    files_sent++;
  endtask

  // Hold off the sender until every predicted result has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // file ends inside the preamble
    add_junk(10);
    send_file();

    // file ends inside the prefix
    add_preamble();
    file_q.push_back(PREFIX_WORD[31:24]);
    file_q.push_back(PREFIX_WORD[23:16]);
    send_file();

    // prefix mismatch, later bytes ignored
    add_preamble();
    add_prefix();
    file_q[PREAMBLE_BYTES + 3] = "X";
    add_junk(6);
    send_file();

    // prefix mismatch on the final byte
    add_preamble();
    add_prefix();
    file_q[PREAMBLE_BYTES] = "X";
    send_file();

    // every header form, tag extremes, two encapsulations, header ends on final byte;
    // no idling on either side for this whole file
    calm <= 1'b1;
    add_preamble();
    add_prefix();
    add_element(16'h0002, 16'h0000, "UL", VRC_SHORT, 4, WHOLE_VALUE);
    add_element(16'h0000, 16'hFFFF, "AE", VRC_SHORT, 0, WHOLE_VALUE);
    add_element(16'hFFFF, 16'h0000, "UN", VRC_LONG, UNDEF_LEN, WHOLE_VALUE);
    add_element(16'h0008, 16'h1234, 16'h0, VRC_IMPLICIT, 3, WHOLE_VALUE);
    add_element(TAG_ITEM_GROUP, TAG_ITEM, 16'h0, VRC_IMPLICIT, 2, WHOLE_VALUE);
    add_element(TAG_PIXEL_GROUP, TAG_PIXEL_ELEMENT, "OW", VRC_LONG, 4, WHOLE_VALUE);
    add_encapsulation(2, 1'b1);
    add_encapsulation(1, 1'b0);
    add_element(16'h0010, 16'h0020, "SH", VRC_SHORT, 0, WHOLE_VALUE);
    send_file();
    calm <= 1'b0;

    // header cut off by the end of the file
    add_preamble();
    add_prefix();
    add_element(16'h0010, 16'h0010, "PN", VRC_SHORT, 4, WHOLE_VALUE);
    add_junk(5);
    send_file();

    // largest long length, value cut off by the end of the file
    add_preamble();
    add_prefix();
    add_element(16'hFFFF, 16'hFFFF, "OB", VRC_LONG, 32'hFFFF_FFFE, 2);
    send_file();

    wait_drained();

    // random files: mostly well formed, some broken
    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        add_junk($urandom_range(1, PREAMBLE_BYTES + 3));
      end else if (pick < 11) begin
        add_preamble();
        add_prefix();
        idx = PREAMBLE_BYTES + $urandom_range(3);
        file_q[idx] = file_q[idx] ^ (8'h01 << $urandom_range(7));
        add_junk($urandom_range(12));
      end else begin
        add_preamble();
        add_prefix();
        repeat ($urandom_range(3, 14)) add_random_element();
        case ($urandom_range(9))
          0, 1: add_junk($urandom_range(1, 7));
          2: add_element(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                         pick_vr(VRC_LONG), VRC_LONG,
                         ($urandom | 32'h8000_0000) & 32'hFFFF_FFFE, $urandom_range(5));
          3: add_element(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                         pick_vr(VRC_SHORT), VRC_SHORT, $urandom_range(65535),
                         $urandom_range(3));
          4: add_junk($urandom_range(4, 16));
          default: ;
        endcase
      end
      send_file();
      if (files_sent % 5 == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d files (%0d bytes in all) and %0d result transactions,",
             files_sent, bytes_sent, results_checked);
    $display("with random gaps and stalls on both channels and one calm stretch.");
    if (mismatches == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
